### rtl/core/pgpc_pkg.sv
// Shared constants and types for the prime-gcd pair counter.
package pgpc_pkg;

  // Largest limit the tables cover
  localparam int unsigned MaxValue   = 65536;
  // Width of a limit, an index or a quotient
  localparam int unsigned ValW       = 17;
  // Address width and depth of the per-value table
  localparam int unsigned NumDepth   = MaxValue + 1;
  localparam int unsigned NumAw      = $clog2(NumDepth);
  // Prime list: 6542 primes lie below MaxValue
  localparam int unsigned PrimeDepth = 8192;
  localparam int unsigned PrimeAw    = $clog2(PrimeDepth);
  // Width of the prefix sums and of the result
  localparam int unsigned GW         = 32;
  localparam int unsigned SumW       = 33;
  // Divider: two quotient bits per cycle over an even-padded dividend
  localparam int unsigned DivW       = ValW + 1;
  localparam int unsigned DivIter    = DivW / 2;
  localparam int unsigned DivCntW    = $clog2(DivIter + 1);

  // One entry of the per-value table: lowest prime factor, mu, and g or F
  typedef struct packed {
    logic [ValW-1:0]        lpf;
    logic signed [1:0]      mu;
    logic signed [GW-1:0]   g;
  } num_word_t;

endpackage

### rtl/core/pgpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pgpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write on request, register every read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/pgpc_div.sv
// Iterative unsigned divider, two restoring steps per cycle.
module pgpc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pgpc_pkg::ValW-1:0] dividend_i,
  input  logic [pgpc_pkg::ValW-1:0] divisor_i,
  output logic                      done_o,
  output logic [pgpc_pkg::ValW-1:0] quotient_o
);
  import pgpc_pkg::*;

  logic [ValW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [ValW-1:0]    dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  // Two dependent restoring steps
  always_comb begin
    logic [DivW-1:0] t;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int s = 0; s < 2; s++) begin
      t     = {rem_d, quo_d[DivW-1]};
      quo_d = {quo_d[DivW-2:0], 1'b0};
      if (t >= {1'b0, dvs_q}) begin
        t        = t - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = t[ValW-1:0];
    end
  end

  // Load on start, advance while busy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivIter);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= {1'b0, dividend_i};
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[ValW-1:0];

endmodule

### rtl/core/prime_gcd_pair_counter.sv
// Top level: sieve at reset, then counts pairs whose gcd is prime per query.
// Reset: clears the value table, runs a linear sieve (StSRd, StSGet, StSPRd per value plus
// StSPRd, StSPGet, StSMark per prime tried) and a prefix pass (StPRd, StPAcc per value);
// in_ready_o is low until all of this is finished. Query: per block of equal quotients, four
// divisions in one shared radix-4 divider, then reads, multiplies and sum,
// about 2*sqrt(n) blocks; one query in work, a held result does not block the next transfer.
module prime_gcd_pair_counter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [pgpc_pkg::ValW-1:0] limit_a_i,
  input  logic [pgpc_pkg::ValW-1:0] limit_b_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [pgpc_pkg::SumW-1:0] pair_count_o
);
  import pgpc_pkg::*;

  typedef enum logic [4:0] {
    StClear, StSRd, StSGet, StSPRd, StSPGet, StSMark,
    StPRd, StPAcc,
    StIdle, StQDStart, StQDWait, StQRdJ, StQRdI, StQDiff,
    StQMul1, StQMul2, StQAcc, StOut
  } state_e;

  state_e               state_q, state_d;
  logic [ValW-1:0]      i_q, i_d;
  logic [PrimeAw-1:0]   k_q, k_d;
  logic [PrimeAw-1:0]   ptot_q, ptot_d;
  logic [ValW-1:0]      lpfi_q, lpfi_d;
  logic signed [1:0]    mui_q, mui_d;
  logic signed [GW-1:0] gi_q, gi_d;
  logic [2*ValW-1:0]    prod_q, prod_d;
  logic [ValW-1:0]      p_q, p_d;
  logic [ValW-1:0]      n_q, n_d, m_q, m_d, lo_q, lo_d;
  logic [ValW-1:0]      qn_q, qn_d, qm_q, qm_d, jn_q, jn_d, j_q, j_d;
  logic [1:0]           dsel_q, dsel_d;
  logic signed [GW-1:0] fj_q, fj_d;
  logic [SumW-1:0]      diff_q, diff_d, t_q, t_d, sum_q, sum_d;
  logic                 sieved_q, sieved_d;
  logic                 out_valid_q, out_valid_d;
  logic [SumW-1:0]      out_q, out_d;

  // Table ports
  logic             num_we;
  logic [NumAw-1:0] num_waddr, num_raddr;
  num_word_t        num_wdata, num_rdata;
  logic             pr_we;
  logic [ValW-1:0]  pr_wdata, pr_rdata;

  // Shared divider and multiplier
  logic            div_start, div_done;
  logic [ValW-1:0] div_a, div_b, div_q;
  logic [SumW-1:0] mul_a;
  logic [ValW-1:0] mul_b;
  logic [SumW+ValW-1:0] mul_p;

  pgpc_ram #(
    .Width ($bits(num_word_t)),
    .Depth (NumDepth)
  ) u_num_ram (
    .clk_i   (clk_i),
    .we_i    (num_we),
    .waddr_i (num_waddr),
    .wdata_i (num_wdata),
    .raddr_i (num_raddr),
    .rdata_o (num_rdata)
  );

  pgpc_ram #(
    .Width (ValW),
    .Depth (PrimeDepth)
  ) u_prime_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (ptot_q),
    .wdata_i (pr_wdata),
    .raddr_i (k_q),
    .rdata_o (pr_rdata)
  );

  pgpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign mul_p = mul_a * mul_b;

  // Divider operands follow the division in turn
  always_comb begin
    case (dsel_q)
      2'd0:    begin div_a = n_q; div_b = i_q;  end
      2'd1:    begin div_a = m_q; div_b = i_q;  end
      2'd2:    begin div_a = n_q; div_b = qn_q; end
      default: begin div_a = m_q; div_b = qm_q; end
    endcase
  end

  // Sequencer
  always_comb begin
    logic [ValW-1:0] jm;
    jm          = div_q;
    state_d     = state_q;
    i_d         = i_q;
    k_d         = k_q;
    ptot_d      = ptot_q;
    lpfi_d      = lpfi_q;
    mui_d       = mui_q;
    gi_d        = gi_q;
    prod_d      = prod_q;
    p_d         = p_q;
    n_d         = n_q;
    m_d         = m_q;
    lo_d        = lo_q;
    qn_d        = qn_q;
    qm_d        = qm_q;
    jn_d        = jn_q;
    j_d         = j_q;
    dsel_d      = dsel_q;
    fj_d        = fj_q;
    diff_d      = diff_q;
    t_d         = t_q;
    sum_d       = sum_q;
    sieved_d    = sieved_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    num_we      = 1'b0;
    num_waddr   = i_q;
    num_wdata   = '0;
    num_raddr   = i_q;
    pr_we       = 1'b0;
    pr_wdata    = i_q;
    div_start   = 1'b0;
    mul_a       = diff_q;
    mul_b       = qn_q;
    in_ready_o  = 1'b0;

    // Drop the result once it is taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      // Clear the value table, one entry a cycle
      StClear: begin
        num_we = 1'b1;
        if (i_q == ValW'(MaxValue)) begin
          i_d     = ValW'(2);
          state_d = StSRd;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      StSRd: begin
        state_d = StSGet;
      end
      // Record a new prime or pick up what earlier passes left
      StSGet: begin
        if (num_rdata.lpf == '0) begin
          num_we         = 1'b1;
          num_wdata.lpf  = i_q;
          num_wdata.mu   = -2'sd1;
          num_wdata.g    = GW'(1);
          pr_we          = 1'b1;
          ptot_d         = ptot_q + 1'b1;
          lpfi_d         = i_q;
          mui_d          = -2'sd1;
          gi_d           = GW'(1);
        end else begin
          lpfi_d = num_rdata.lpf;
          mui_d  = num_rdata.mu;
          gi_d   = num_rdata.g;
        end
        k_d     = '0;
        state_d = StSPRd;
      end
      StSPRd: begin
        if (k_q == ptot_q) begin
          state_d = StSRd;
          if (i_q == ValW'(MaxValue)) begin
            i_d     = ValW'(1);
            sum_d   = '0;
            state_d = StPRd;
          end else begin
            i_d = i_q + 1'b1;
          end
        end else begin
          state_d = StSPGet;
        end
      end
      // Form p * i
      StSPGet: begin
        mul_a   = SumW'(pr_rdata);
        mul_b   = i_q;
        prod_d  = mul_p[2*ValW-1:0];
        p_d     = pr_rdata;
        state_d = StSMark;
      end
      // Mark p * i and stop at the lowest prime factor of i or once p * i exceeds MaxValue
      StSMark: begin
        if (prod_q > (2*ValW)'(MaxValue)) begin
          k_d     = ptot_q;
          state_d = StSPRd;
        end else begin
          num_we        = 1'b1;
          num_waddr     = prod_q[NumAw-1:0];
          num_wdata.lpf = p_q;
          if (p_q == lpfi_q) begin
            num_wdata.mu = 2'sd0;
            num_wdata.g  = GW'(mui_q);
            k_d          = ptot_q;
          end else begin
            num_wdata.mu = -mui_q;
            num_wdata.g  = GW'(mui_q) - gi_q;
            k_d          = k_q + 1'b1;
          end
          state_d = StSPRd;
        end
      end
      StPRd: begin
        state_d = StPAcc;
      end
      // Turn g into running prefix sums in place
      StPAcc: begin
        num_we        = 1'b1;
        num_wdata     = num_rdata;
        num_wdata.g   = sum_q[GW-1:0] + num_rdata.g;
        sum_d         = SumW'(num_wdata.g);
        if (i_q == ValW'(MaxValue)) begin
          sieved_d = 1'b1;
          state_d  = StIdle;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = StPRd;
        end
      end
      // Take a query
      StIdle: begin
        in_ready_o = sieved_q;
        if (in_valid_i && sieved_q) begin
          n_d    = limit_a_i;
          m_d    = limit_b_i;
          lo_d   = (limit_a_i < limit_b_i) ? limit_a_i : limit_b_i;
          i_d    = ValW'(1);
          sum_d  = '0;
          dsel_d = 2'd0;
          if (limit_a_i > ValW'(MaxValue) || limit_b_i > ValW'(MaxValue) ||
              lo_d == '0) begin
            state_d = StOut;
          end else begin
            state_d = StQDStart;
          end
        end
      end
      StQDStart: begin
        div_start = 1'b1;
        state_d   = StQDWait;
      end
      // Collect n/i, m/i, n/qn and m/qm in turn
      StQDWait: begin
        if (div_done) begin
          case (dsel_q)
            2'd0:    qn_d = div_q;
            2'd1:    qm_d = div_q;
            2'd2:    jn_d = div_q;
            default: j_d  = (jn_q < jm) ? jn_q : jm;
          endcase
          if (dsel_q == 2'd3) begin
            state_d = StQRdJ;
          end else begin
            dsel_d  = dsel_q + 1'b1;
            state_d = StQDStart;
          end
        end
      end
      StQRdJ: begin
        num_raddr = j_q;
        state_d   = StQRdI;
      end
      StQRdI: begin
        fj_d      = num_rdata.g;
        num_raddr = i_q - 1'b1;
        state_d   = StQDiff;
      end
      StQDiff: begin
        diff_d  = SumW'(fj_q) - SumW'(num_rdata.g);
        state_d = StQMul1;
      end
      StQMul1: begin
        t_d     = mul_p[SumW-1:0];
        state_d = StQMul2;
      end
      StQMul2: begin
        mul_a   = t_q;
        mul_b   = qm_q;
        t_d     = mul_p[SumW-1:0];
        state_d = StQAcc;
      end
      // Accumulate and move to the next block
      StQAcc: begin
        sum_d  = sum_q + t_q;
        dsel_d = 2'd0;
        if (j_q >= lo_q) begin
          state_d = StOut;
        end else begin
          i_d     = j_q + 1'b1;
          state_d = StQDStart;
        end
      end
      // Hand the result to the output register when it is free
      StOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = sum_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      i_q         <= '0;
      k_q         <= '0;
      ptot_q      <= '0;
      dsel_q      <= '0;
      sieved_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      k_q         <= k_d;
      ptot_q      <= ptot_d;
      dsel_q      <= dsel_d;
      sieved_q    <= sieved_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    lpfi_q <= lpfi_d;
    mui_q  <= mui_d;
    gi_q   <= gi_d;
    prod_q <= prod_d;
    p_q    <= p_d;
    n_q    <= n_d;
    m_q    <= m_d;
    lo_q   <= lo_d;
    qn_q   <= qn_d;
    qm_q   <= qm_d;
    jn_q   <= jn_d;
    j_q    <= j_d;
    fj_q   <= fj_d;
    diff_q <= diff_d;
    t_q    <= t_d;
    sum_q  <= sum_d;
    out_q  <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign pair_count_o = out_q;

endmodule
